// File: src/dtpc_pkg.sv
// Shared constants and types for the depth to point cloud block.
// Used by the channel interfaces and the top level; depends on nothing.
package dtpc_pkg;

  // Width to which pixel column and row are taken.
  localparam int COORD_BITS = 12;

  // Field widths of the channels.
  localparam int DEPTH_W  = 16;
  localparam int PIX_W    = 12;
  localparam int COLOUR_W = 8;
  localparam int RECIP_W  = 24;
  localparam int CENTRE_W = 13;
  localparam int STRIDE_W = 2;
  localparam int Z_W      = 24;
  localparam int XY_W     = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // Fixed-point shifts.
  localparam int Z_SHIFT    = 8;
  localparam int FRAC_SHIFT = 25;

  // Number of register stages in the projection pipeline.
  localparam int NSTG = 6;

  // Datapath widths that follow from the coordinate width.
  localparam int MAG_W  = (COORD_BITS + 1 > CENTRE_W) ? COORD_BITS + 1 : CENTRE_W;
  localparam int ZP_W   = DEPTH_W + RECIP_W;
  localparam int MZ_W   = MAG_W + Z_W;
  localparam int LO_W   = MZ_W / 2;
  localparam int HI_W   = MZ_W - LO_W;
  localparam int PROD_W = MZ_W + RECIP_W;
  localparam int Q_W    = PROD_W - FRAC_SHIFT;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_RECIP   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X_HALF = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y_HALF = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X_RECIP = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y_RECIP = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_LOG2   = 8'd5;

  // Register values after reset.
  localparam logic [RECIP_W-1:0]  DEPTH_RECIP_RST   = 24'd16777;
  localparam logic [CENTRE_W-1:0] CENTER_X_HALF_RST = 13'd651;
  localparam logic [CENTRE_W-1:0] CENTER_Y_HALF_RST = 13'd507;
  localparam logic [RECIP_W-1:0]  FOCAL_X_RECIP_RST = 24'd32388;
  localparam logic [RECIP_W-1:0]  FOCAL_Y_RECIP_RST = 24'd32326;
  localparam logic [STRIDE_W-1:0] STRIDE_LOG2_RST   = 2'd1;

  localparam logic [Z_W-1:0]  Z_MAX   = 24'hFF_FFFF;
  localparam logic [XY_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [XY_W-1:0] NEG_MAX = 32'h8000_0000;

endpackage

// File: src/dtpc_in_if.sv
// Pixel input channel: valid, ready and one RGB-D pixel.
// Depends on dtpc_pkg for the field widths.
interface dtpc_in_if;
  logic                             valid;
  logic                             ready;
  logic [dtpc_pkg::DEPTH_W-1:0]     depth_raw;
  logic [dtpc_pkg::PIX_W-1:0]       pixel_col;
  logic [dtpc_pkg::PIX_W-1:0]       pixel_row;
  logic [dtpc_pkg::COLOUR_W-1:0]    red;
  logic [dtpc_pkg::COLOUR_W-1:0]    green;
  logic [dtpc_pkg::COLOUR_W-1:0]    blue;

  modport source (output valid, depth_raw, pixel_col, pixel_row, red, green, blue,
                  input ready);
  modport sink   (input valid, depth_raw, pixel_col, pixel_row, red, green, blue,
                  output ready);
endinterface

// File: src/dtpc_out_if.sv
// Point output channel: valid, ready and one coloured 3-D point.
// Depends on dtpc_pkg for the field widths.
interface dtpc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dtpc_pkg::XY_W-1:0]    point_x;
  logic signed [dtpc_pkg::XY_W-1:0]    point_y;
  logic [dtpc_pkg::Z_W-1:0]            point_z;
  logic [dtpc_pkg::COLOUR_W-1:0]       point_red;
  logic [dtpc_pkg::COLOUR_W-1:0]       point_green;
  logic [dtpc_pkg::COLOUR_W-1:0]       point_blue;

  modport source (output valid, point_x, point_y, point_z, point_red, point_green,
                  point_blue, input ready);
  modport sink   (input valid, point_x, point_y, point_z, point_red, point_green,
                  point_blue, output ready);
endinterface

// File: src/dtpc_cfg_if.sv
// Configuration write channel: valid, ready, register index and write data.
// Depends on dtpc_pkg for the field widths.
interface dtpc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [dtpc_pkg::CFG_IDX_W-1:0]     index;
  logic [dtpc_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/depth_to_point_cloud.sv
// Top level of the depth to point cloud block: configuration registers and the
// six-stage projection pipeline. Depends on dtpc_pkg and the three channel interfaces.
//
// One pixel request is taken every clock cycle while the input is not refused,
// and each pixel passes in order through the six register stages (depth scale,
// z saturation, offset times z, split reciprocal products, product
// sum, rounding and saturation). Pixels with zero depth or off the sampling grid
// are dropped at the input and leave no point. Each stage moves on when its
// successor is empty or moving, so bubbles close up and input is refused only
// when all six stages hold a point and the output is stalled. Configuration
// writes are always accepted and must be made while no point is in flight.
module depth_to_point_cloud (
  input  logic        clk,
  input  logic        rst_n,
  dtpc_in_if.sink     in_pix,
  dtpc_out_if.source  out_pt,
  dtpc_cfg_if.sink    cfg_wr
);

  typedef struct packed {
    logic [dtpc_pkg::ZP_W-1:0]        zp;
    logic [dtpc_pkg::MAG_W-1:0]       magx;
    logic [dtpc_pkg::MAG_W-1:0]       magy;
    logic                             negx;
    logic                             negy;
    logic [3*dtpc_pkg::COLOUR_W-1:0]  rgb;
  } s1_t;

  typedef struct packed {
    logic [dtpc_pkg::Z_W-1:0]         z;
    logic [dtpc_pkg::MAG_W-1:0]       magx;
    logic [dtpc_pkg::MAG_W-1:0]       magy;
    logic                             negx;
    logic                             negy;
    logic [3*dtpc_pkg::COLOUR_W-1:0]  rgb;
  } s2_t;

  typedef struct packed {
    logic [dtpc_pkg::Z_W-1:0]         z;
    logic [dtpc_pkg::MZ_W-1:0]        mzx;
    logic [dtpc_pkg::MZ_W-1:0]        mzy;
    logic                             negx;
    logic                             negy;
    logic [3*dtpc_pkg::COLOUR_W-1:0]  rgb;
  } s3_t;

  typedef struct packed {
    logic [dtpc_pkg::Z_W-1:0]                   z;
    logic [dtpc_pkg::LO_W+dtpc_pkg::RECIP_W-1:0] pxl;
    logic [dtpc_pkg::HI_W+dtpc_pkg::RECIP_W-1:0] pxh;
    logic [dtpc_pkg::LO_W+dtpc_pkg::RECIP_W-1:0] pyl;
    logic [dtpc_pkg::HI_W+dtpc_pkg::RECIP_W-1:0] pyh;
    logic                                        negx;
    logic                                        negy;
    logic [3*dtpc_pkg::COLOUR_W-1:0]             rgb;
  } s4_t;

  typedef struct packed {
    logic [dtpc_pkg::Z_W-1:0]         z;
    logic [dtpc_pkg::PROD_W-1:0]      prodx;
    logic [dtpc_pkg::PROD_W-1:0]      prody;
    logic                             negx;
    logic                             negy;
    logic [3*dtpc_pkg::COLOUR_W-1:0]  rgb;
  } s5_t;

  typedef struct packed {
    logic [dtpc_pkg::XY_W-1:0]        x;
    logic [dtpc_pkg::XY_W-1:0]        y;
    logic [dtpc_pkg::Z_W-1:0]         z;
    logic                             negx;
    logic [3*dtpc_pkg::COLOUR_W-1:0]  rgb;
  } s6_t;

  // Configuration registers.
  logic [dtpc_pkg::RECIP_W-1:0]  depth_recip_r;
  logic [dtpc_pkg::CENTRE_W-1:0] center_x_half_r;
  logic [dtpc_pkg::CENTRE_W-1:0] center_y_half_r;
  logic [dtpc_pkg::RECIP_W-1:0]  focal_x_recip_r;
  logic [dtpc_pkg::RECIP_W-1:0]  focal_y_recip_r;
  logic [dtpc_pkg::STRIDE_W-1:0] stride_log2_r;

  logic [dtpc_pkg::NSTG-1:0] v_r;
  logic [dtpc_pkg::NSTG-1:0] v_nxt;
  logic [dtpc_pkg::NSTG-1:0] en;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  s6_t s6_r, s6_nxt;

  logic                             keep;
  logic [dtpc_pkg::COORD_BITS-1:0]  col_m;
  logic [dtpc_pkg::COORD_BITS-1:0]  row_m;
  logic [dtpc_pkg::COORD_BITS-1:0]  grid_mask;
  logic [dtpc_pkg::MAG_W-1:0]       twice_x;
  logic [dtpc_pkg::MAG_W-1:0]       twice_y;
  logic [dtpc_pkg::MAG_W-1:0]       cen_x;
  logic [dtpc_pkg::MAG_W-1:0]       cen_y;
  logic [dtpc_pkg::ZP_W-dtpc_pkg::Z_SHIFT-1:0] z_wide;

  // Floor for positive offsets and ceiling of the magnitude for negative ones,
  // then saturation to the signed 32-bit range.
  function automatic logic [dtpc_pkg::XY_W-1:0] round_sat(
    input logic [dtpc_pkg::PROD_W-1:0] prod,
    input logic                        neg
  );
    logic [dtpc_pkg::Q_W-1:0]  f;
    logic                      r;
    logic [dtpc_pkg::XY_W-1:0] res;
    f = prod[dtpc_pkg::PROD_W-1:dtpc_pkg::FRAC_SHIFT];
    r = |prod[dtpc_pkg::FRAC_SHIFT-1:0];
    if (!neg) begin
      if (f > dtpc_pkg::Q_W'(dtpc_pkg::POS_MAX)) begin
        res = dtpc_pkg::POS_MAX;
      end else begin
        res = f[dtpc_pkg::XY_W-1:0];
      end
    end else begin
      if (f > dtpc_pkg::Q_W'(dtpc_pkg::NEG_MAX) ||
          (f == dtpc_pkg::Q_W'(dtpc_pkg::NEG_MAX) && r)) begin
        res = dtpc_pkg::NEG_MAX;
      end else if (r) begin
        // -(f + 1) is the plain complement of f.
        res = ~f[dtpc_pkg::XY_W-1:0];
      end else begin
        res = ~f[dtpc_pkg::XY_W-1:0] + dtpc_pkg::XY_W'(1);
      end
    end
    return res;
  endfunction

  // Configuration port.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_recip_r   <= dtpc_pkg::DEPTH_RECIP_RST;
      center_x_half_r <= dtpc_pkg::CENTER_X_HALF_RST;
      center_y_half_r <= dtpc_pkg::CENTER_Y_HALF_RST;
      focal_x_recip_r <= dtpc_pkg::FOCAL_X_RECIP_RST;
      focal_y_recip_r <= dtpc_pkg::FOCAL_Y_RECIP_RST;
      stride_log2_r   <= dtpc_pkg::STRIDE_LOG2_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        dtpc_pkg::REG_DEPTH_RECIP:   depth_recip_r   <= cfg_wr.data[dtpc_pkg::RECIP_W-1:0];
        dtpc_pkg::REG_CENTER_X_HALF: center_x_half_r <= cfg_wr.data[dtpc_pkg::CENTRE_W-1:0];
        dtpc_pkg::REG_CENTER_Y_HALF: center_y_half_r <= cfg_wr.data[dtpc_pkg::CENTRE_W-1:0];
        dtpc_pkg::REG_FOCAL_X_RECIP: focal_x_recip_r <= cfg_wr.data[dtpc_pkg::RECIP_W-1:0];
        dtpc_pkg::REG_FOCAL_Y_RECIP: focal_y_recip_r <= cfg_wr.data[dtpc_pkg::RECIP_W-1:0];
        dtpc_pkg::REG_STRIDE_LOG2:   stride_log2_r   <= cfg_wr.data[dtpc_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage may load when it is empty or its contents move on.
  always_comb begin
    en[dtpc_pkg::NSTG-1] = !v_r[dtpc_pkg::NSTG-1] || out_pt.ready;
    for (int k = dtpc_pkg::NSTG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_pix.ready = en[0];

  // Stage 1: depth scale, offsets from the principal point and the keep test.
  always_comb begin
    col_m     = dtpc_pkg::COORD_BITS'(in_pix.pixel_col);
    row_m     = dtpc_pkg::COORD_BITS'(in_pix.pixel_row);
    grid_mask = ~({dtpc_pkg::COORD_BITS{1'b1}} << stride_log2_r);
    keep      = (in_pix.depth_raw != '0) && ((col_m & grid_mask) == '0) &&
                ((row_m & grid_mask) == '0);
    twice_x   = dtpc_pkg::MAG_W'({col_m, 1'b0});
    twice_y   = dtpc_pkg::MAG_W'({row_m, 1'b0});
    cen_x     = dtpc_pkg::MAG_W'(center_x_half_r);
    cen_y     = dtpc_pkg::MAG_W'(center_y_half_r);
    s1_nxt.zp   = dtpc_pkg::ZP_W'(in_pix.depth_raw) * dtpc_pkg::ZP_W'(depth_recip_r);
    s1_nxt.negx = twice_x < cen_x;
    s1_nxt.negy = twice_y < cen_y;
    s1_nxt.magx = s1_nxt.negx ? cen_x - twice_x : twice_x - cen_x;
    s1_nxt.magy = s1_nxt.negy ? cen_y - twice_y : twice_y - cen_y;
    s1_nxt.rgb  = {in_pix.red, in_pix.green, in_pix.blue};
  end

  // Stage 2: z saturation.
  always_comb begin
    z_wide        = s1_r.zp[dtpc_pkg::ZP_W-1:dtpc_pkg::Z_SHIFT];
    s2_nxt.z      = (z_wide > (dtpc_pkg::ZP_W-dtpc_pkg::Z_SHIFT)'(dtpc_pkg::Z_MAX)) ?
                    dtpc_pkg::Z_MAX : z_wide[dtpc_pkg::Z_W-1:0];
    s2_nxt.magx   = s1_r.magx;
    s2_nxt.magy   = s1_r.magy;
    s2_nxt.negx   = s1_r.negx;
    s2_nxt.negy   = s1_r.negy;
    s2_nxt.rgb    = s1_r.rgb;
  end

  // Stage 3: offset magnitude times z.
  always_comb begin
    s3_nxt.z    = s2_r.z;
    s3_nxt.mzx  = dtpc_pkg::MZ_W'(s2_r.magx) * dtpc_pkg::MZ_W'(s2_r.z);
    s3_nxt.mzy  = dtpc_pkg::MZ_W'(s2_r.magy) * dtpc_pkg::MZ_W'(s2_r.z);
    s3_nxt.negx = s2_r.negx;
    s3_nxt.negy = s2_r.negy;
    s3_nxt.rgb  = s2_r.rgb;
  end

  // Stage 4: the reciprocal product in two halves to keep each multiplier narrow.
  always_comb begin
    s4_nxt.z    = s3_r.z;
    s4_nxt.pxl  = (dtpc_pkg::LO_W + dtpc_pkg::RECIP_W)'(s3_r.mzx[dtpc_pkg::LO_W-1:0]) *
                  (dtpc_pkg::LO_W + dtpc_pkg::RECIP_W)'(focal_x_recip_r);
    s4_nxt.pxh  = (dtpc_pkg::HI_W + dtpc_pkg::RECIP_W)'(
                    s3_r.mzx[dtpc_pkg::MZ_W-1:dtpc_pkg::LO_W]) *
                  (dtpc_pkg::HI_W + dtpc_pkg::RECIP_W)'(focal_x_recip_r);
    s4_nxt.pyl  = (dtpc_pkg::LO_W + dtpc_pkg::RECIP_W)'(s3_r.mzy[dtpc_pkg::LO_W-1:0]) *
                  (dtpc_pkg::LO_W + dtpc_pkg::RECIP_W)'(focal_y_recip_r);
    s4_nxt.pyh  = (dtpc_pkg::HI_W + dtpc_pkg::RECIP_W)'(
                    s3_r.mzy[dtpc_pkg::MZ_W-1:dtpc_pkg::LO_W]) *
                  (dtpc_pkg::HI_W + dtpc_pkg::RECIP_W)'(focal_y_recip_r);
    s4_nxt.negx = s3_r.negx;
    s4_nxt.negy = s3_r.negy;
    s4_nxt.rgb  = s3_r.rgb;
  end

  // Stage 5: sum of the partial products.
  always_comb begin
    s5_nxt.z     = s4_r.z;
    s5_nxt.prodx = (dtpc_pkg::PROD_W'(s4_r.pxh) << dtpc_pkg::LO_W) +
                   dtpc_pkg::PROD_W'(s4_r.pxl);
    s5_nxt.prody = (dtpc_pkg::PROD_W'(s4_r.pyh) << dtpc_pkg::LO_W) +
                   dtpc_pkg::PROD_W'(s4_r.pyl);
    s5_nxt.negx  = s4_r.negx;
    s5_nxt.negy  = s4_r.negy;
    s5_nxt.rgb   = s4_r.rgb;
  end

  // Stage 6: rounding, sign and saturation into the output register.
  always_comb begin
    s6_nxt.x    = round_sat(s5_r.prodx, s5_r.negx);
    s6_nxt.y    = round_sat(s5_r.prody, s5_r.negy);
    s6_nxt.z    = s5_r.z;
    s6_nxt.negx = s5_r.negx;
    s6_nxt.rgb  = s5_r.rgb;
  end

  always_comb begin
    v_nxt[0] = en[0] ? (in_pix.valid && keep) : v_r[0];
    for (int k = 1; k < dtpc_pkg::NSTG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_r <= s1_nxt;
    end
    if (en[1]) begin
      s2_r <= s2_nxt;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
    if (en[3]) begin
      s4_r <= s4_nxt;
    end
    if (en[4]) begin
      s5_r <= s5_nxt;
    end
    if (en[5]) begin
      s6_r <= s6_nxt;
    end
  end

  assign out_pt.valid       = v_r[dtpc_pkg::NSTG-1];
  assign out_pt.point_x     = s6_r.x;
  assign out_pt.point_y     = s6_r.y;
  assign out_pt.point_z     = s6_r.z;
  assign out_pt.point_red   = s6_r.rgb[3*dtpc_pkg::COLOUR_W-1:2*dtpc_pkg::COLOUR_W];
  assign out_pt.point_green = s6_r.rgb[2*dtpc_pkg::COLOUR_W-1:dtpc_pkg::COLOUR_W];
  assign out_pt.point_blue  = s6_r.rgb[dtpc_pkg::COLOUR_W-1:0];

  // Input is only refused when every stage is full.
  a_full_when_refused: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (&v_r))
    else $error("input refused with a bubble in the pipeline");

  // A taken pixel enters the first stage exactly when it passes the keep test.
  a_entry_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> (v_r[0] == $past(keep)))
    else $error("first stage valid does not follow the keep test");

  // A held fifth stage keeps its point.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[4] && !en[5]) |=> (v_r[4] && $stable(s5_r)))
    else $error("stalled stage lost or changed its point");

  // A point right of the principal point never comes out negative.
  a_sign_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pt.valid && !s6_r.negx) |-> !out_pt.point_x[dtpc_pkg::XY_W-1])
    else $error("non-negative offset gave a negative x");

endmodule

// File: verif/depth_to_point_cloud_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for depth_to_point_cloud: directed pixels, then random streams.
// Depends on dtpc_pkg, the three channel interfaces and the block's top level.
module depth_to_point_cloud_test;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int DRAIN_CYCLES    = 12;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int REPORT_LIMIT    = 10;
  localparam int RANDOM_PHASES   = 10;
  localparam int PHASE_ITEMS     = 95;

  // Indexes that name no register.
  localparam logic [dtpc_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd6;
  localparam logic [dtpc_pkg::CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

  typedef struct packed {
    logic signed [dtpc_pkg::XY_W-1:0] x;
    logic signed [dtpc_pkg::XY_W-1:0] y;
    logic [dtpc_pkg::Z_W-1:0]         z;
    logic [dtpc_pkg::COLOUR_W-1:0]    red;
    logic [dtpc_pkg::COLOUR_W-1:0]    green;
    logic [dtpc_pkg::COLOUR_W-1:0]    blue;
  } point_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dtpc_in_if  pix_if ();
  dtpc_out_if pt_if ();
  dtpc_cfg_if cfg_if ();

  depth_to_point_cloud u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_if),
    .out_pt (pt_if),
    .cfg_wr (cfg_if)
  );

  point_t expected_points[$];
  int     error_count      = 0;
  int     cycle_count      = 0;
  int     burst_left       = 0;
  int     hold_offs_asked  = 0;
  int     hold_offs_served = 0;

  // Register copies kept by the scoreboard.
  logic [dtpc_pkg::RECIP_W-1:0]  scale_recip;
  logic [dtpc_pkg::CENTRE_W-1:0] centre_x2;
  logic [dtpc_pkg::CENTRE_W-1:0] centre_y2;
  logic [dtpc_pkg::RECIP_W-1:0]  inv_fx;
  logic [dtpc_pkg::RECIP_W-1:0]  inv_fy;
  logic [dtpc_pkg::STRIDE_W-1:0] grid_log2;

  always #HALF_PERIOD clk = ~clk;

  // One axis: (2*pix - centre2) * z * recip, floored shift by FRAC_SHIFT, saturated.
  function automatic logic [dtpc_pkg::XY_W-1:0] project_axis(input logic [63:0] pix,
                                                             input logic [63:0] centre2,
                                                             input logic [63:0] z,
                                                             input logic [63:0] recip);
    logic [63:0] twice;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] q;
    logic        neg;
    twice = pix << 1;
    neg   = twice < centre2;
    mag   = neg ? centre2 - twice : twice - centre2;
    prod  = mag * z * recip;
    if (!neg) begin
      q = prod >> dtpc_pkg::FRAC_SHIFT;
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    end else begin
      // Flooring a negative value rounds its magnitude up.
      q = (prod + ((64'd1 << dtpc_pkg::FRAC_SHIFT) - 64'd1)) >> dtpc_pkg::FRAC_SHIFT;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      q = 64'h1_0000_0000 - q;
    end
    return q[dtpc_pkg::XY_W-1:0];
  endfunction

  function automatic bit predict_point(input logic [dtpc_pkg::DEPTH_W-1:0] depth,
                                       input logic [dtpc_pkg::PIX_W-1:0] col,
                                       input logic [dtpc_pkg::PIX_W-1:0] row,
                                       input logic [dtpc_pkg::COLOUR_W-1:0] r,
                                       input logic [dtpc_pkg::COLOUR_W-1:0] g,
                                       input logic [dtpc_pkg::COLOUR_W-1:0] b,
                                       output point_t pt);
    logic [63:0] coord_mask;
    logic [63:0] grid_mask;
    logic [63:0] c;
    logic [63:0] rw;
    logic [63:0] d;
    logic [63:0] k;
    logic [63:0] z;
    pt         = '0;
    coord_mask = (64'd1 << dtpc_pkg::COORD_BITS) - 64'd1;
    grid_mask  = (64'd1 << grid_log2) - 64'd1;
    c          = 64'(col);
    rw         = 64'(row);
    c          = c & coord_mask;
    rw         = rw & coord_mask;
    if (depth == '0) return 1'b0;
    if ((c & grid_mask) != 64'd0 || (rw & grid_mask) != 64'd0) return 1'b0;
    d = 64'(depth);
    k = 64'(scale_recip);
    z = (d * k) >> dtpc_pkg::Z_SHIFT;
    if (z > 64'(dtpc_pkg::Z_MAX)) z = 64'(dtpc_pkg::Z_MAX);
    pt.x     = project_axis(c, {51'd0, centre_x2}, z, {40'd0, inv_fx});
    pt.y     = project_axis(rw, {51'd0, centre_y2}, z, {40'd0, inv_fy});
    pt.z     = z[dtpc_pkg::Z_W-1:0];
    pt.red   = r;
    pt.green = g;
    pt.blue  = b;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : scoreboard
    point_t want;
    point_t seen;
    if (!rst_n) begin
      scale_recip = dtpc_pkg::DEPTH_RECIP_RST;
      centre_x2   = dtpc_pkg::CENTER_X_HALF_RST;
      centre_y2   = dtpc_pkg::CENTER_Y_HALF_RST;
      inv_fx      = dtpc_pkg::FOCAL_X_RECIP_RST;
      inv_fy      = dtpc_pkg::FOCAL_Y_RECIP_RST;
      grid_log2   = dtpc_pkg::STRIDE_LOG2_RST;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        seen.x     = pt_if.point_x;
        seen.y     = pt_if.point_y;
        seen.z     = pt_if.point_z;
        seen.red   = pt_if.point_red;
        seen.green = pt_if.point_green;
        seen.blue  = pt_if.point_blue;
        if (expected_points.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected point x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                     seen.x, seen.y, seen.z, seen.red, seen.green, seen.blue);
        end else begin
          want = expected_points.pop_front();
          if (want !== seen) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("point mismatch: expected x=%0d y=%0d z=%0d rgb=%02h%02h%02h,",
                       want.x, want.y, want.z, want.red, want.green, want.blue,
                       " got x=%0d y=%0d z=%0d rgb=%02h%02h%02h",
                       seen.x, seen.y, seen.z, seen.red, seen.green, seen.blue);
          end
        end
      end
      if (pix_if.valid && pix_if.ready) begin
        if (predict_point(pix_if.depth_raw, pix_if.pixel_col, pix_if.pixel_row,
                          pix_if.red, pix_if.green, pix_if.blue, want))
          expected_points = {expected_points, want};
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          dtpc_pkg::REG_DEPTH_RECIP:   scale_recip = cfg_if.data[dtpc_pkg::RECIP_W-1:0];
          dtpc_pkg::REG_CENTER_X_HALF: centre_x2   = cfg_if.data[dtpc_pkg::CENTRE_W-1:0];
          dtpc_pkg::REG_CENTER_Y_HALF: centre_y2   = cfg_if.data[dtpc_pkg::CENTRE_W-1:0];
          dtpc_pkg::REG_FOCAL_X_RECIP: inv_fx      = cfg_if.data[dtpc_pkg::RECIP_W-1:0];
          dtpc_pkg::REG_FOCAL_Y_RECIP: inv_fy      = cfg_if.data[dtpc_pkg::RECIP_W-1:0];
          dtpc_pkg::REG_STRIDE_LOG2:   grid_log2   = cfg_if.data[dtpc_pkg::STRIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Point receiver: stalls on shifting patterns, and holds off for a long stretch on request.
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    mode        = 0;
    mode_left   = 0;
    hold_left   = 0;
    pt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_offs_served != hold_offs_asked) begin
        hold_offs_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pt_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0:       pt_if.ready <= 1'b1;
          1:       pt_if.ready <= 1'($urandom_range(0, 1));
          2:       pt_if.ready <= ($urandom_range(0, 7) != 0);
          default: pt_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    // Dropped pixels leave nothing in the queue, so let the pipeline empty as well.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [dtpc_pkg::CFG_IDX_W-1:0] index,
                                input logic [dtpc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_config(input logic [dtpc_pkg::CFG_DATA_W-1:0] recip,
                             input logic [dtpc_pkg::CFG_DATA_W-1:0] cx2,
                             input logic [dtpc_pkg::CFG_DATA_W-1:0] cy2,
                             input logic [dtpc_pkg::CFG_DATA_W-1:0] fx,
                             input logic [dtpc_pkg::CFG_DATA_W-1:0] fy,
                             input logic [dtpc_pkg::CFG_DATA_W-1:0] stride);
    wait_idle();
    write_register(dtpc_pkg::REG_DEPTH_RECIP, recip);
    write_register(dtpc_pkg::REG_CENTER_X_HALF, cx2);
    write_register(dtpc_pkg::REG_CENTER_Y_HALF, cy2);
    write_register(dtpc_pkg::REG_FOCAL_X_RECIP, fx);
    write_register(dtpc_pkg::REG_FOCAL_Y_RECIP, fy);
    write_register(dtpc_pkg::REG_STRIDE_LOG2, stride);
  endtask

  // Sends one pixel request; the sender runs in bursts with random gaps between them.
  task automatic send_pixel(input logic [dtpc_pkg::DEPTH_W-1:0] depth,
                            input logic [dtpc_pkg::PIX_W-1:0] col,
                            input logic [dtpc_pkg::PIX_W-1:0] row,
                            input logic [dtpc_pkg::COLOUR_W-1:0] r,
                            input logic [dtpc_pkg::COLOUR_W-1:0] g,
                            input logic [dtpc_pkg::COLOUR_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        pix_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    pix_if.valid     <= 1'b1;
    pix_if.depth_raw <= depth;
    pix_if.pixel_col <= col;
    pix_if.pixel_row <= row;
    pix_if.red       <= r;
    pix_if.green     <= g;
    pix_if.blue      <= b;
    do @(posedge clk); while (!pix_if.ready);
    burst_left--;
  endtask

  function automatic logic [dtpc_pkg::CFG_DATA_W-1:0] pick_recip(
    input logic [dtpc_pkg::RECIP_W-1:0] typical);
    logic [31:0] noise;
    noise = $urandom;
    case ($urandom_range(0, 9))
      0:       return 24'hFF_FFFF;
      1:       return 24'd1;
      2:       return noise[dtpc_pkg::CFG_DATA_W-1:0];
      default: return dtpc_pkg::CFG_DATA_W'(typical / 2 + $urandom_range(0, typical));
    endcase
  endfunction

  // Centre and stride draws sometimes set data bits above the register width.
  function automatic logic [dtpc_pkg::CFG_DATA_W-1:0] pick_centre(
    input logic [dtpc_pkg::CENTRE_W-1:0] typical);
    logic [31:0] noise;
    noise = $urandom;
    case ($urandom_range(0, 9))
      0:       return 24'd0;
      1:       return 24'h1FFF;
      2:       return noise[dtpc_pkg::CFG_DATA_W-1:0];
      default: return dtpc_pkg::CFG_DATA_W'($urandom_range(0, 2 * typical));
    endcase
  endfunction

  function automatic logic [dtpc_pkg::CFG_DATA_W-1:0] pick_stride();
    logic [31:0] noise;
    noise = $urandom;
    if ($urandom_range(0, 7) == 0) return noise[dtpc_pkg::CFG_DATA_W-1:0];
    return dtpc_pkg::CFG_DATA_W'($urandom_range(0, 3));
  endfunction

  task automatic send_random_pixel();
    logic [dtpc_pkg::DEPTH_W-1:0] depth;
    logic [dtpc_pkg::PIX_W-1:0]   col;
    logic [dtpc_pkg::PIX_W-1:0]   row;
    logic [dtpc_pkg::PIX_W-1:0]   align;
    logic [31:0]                  noise;
    case ($urandom_range(0, 15))
      0:       depth = '0;
      1:       depth = '1;
      2:       depth = dtpc_pkg::DEPTH_W'($urandom_range(1, 15));
      default: depth = dtpc_pkg::DEPTH_W'($urandom_range(1, 65535));
    endcase
    col   = dtpc_pkg::PIX_W'($urandom_range(0, 4095));
    row   = dtpc_pkg::PIX_W'($urandom_range(0, 4095));
    align = (12'd1 << grid_log2) - 12'd1;
    // Most pixels sit on the sampling grid so that points are plentiful.
    if ($urandom_range(0, 3) != 0) begin
      col = col & ~align;
      row = row & ~align;
    end
    noise = $urandom;
    send_pixel(depth, col, row, noise[7:0], noise[15:8], noise[23:16]);
  endtask

  task automatic test_reset_config();
    send_pixel(16'd1000, 12'd320, 12'd240, 8'h12, 8'h34, 8'h56);
    send_pixel(16'd1, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00);
    send_pixel(16'hFFFF, 12'd4094, 12'd4094, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_no_measurement();
    send_pixel(16'd0, 12'd100, 12'd100, 8'hA5, 8'h5A, 8'hC3);
    send_pixel(16'd0, 12'd4095, 12'd4095, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_sampling_grid();
    load_config(dtpc_pkg::DEPTH_RECIP_RST, dtpc_pkg::CENTER_X_HALF_RST,
                dtpc_pkg::CENTER_Y_HALF_RST, dtpc_pkg::FOCAL_X_RECIP_RST,
                dtpc_pkg::FOCAL_Y_RECIP_RST, 24'd0);
    send_pixel(16'd500, 12'd4095, 12'd4095, 8'h01, 8'h02, 8'h03);
    send_pixel(16'd500, 12'd1, 12'd3, 8'h04, 8'h05, 8'h06);
    load_config(dtpc_pkg::DEPTH_RECIP_RST, dtpc_pkg::CENTER_X_HALF_RST,
                dtpc_pkg::CENTER_Y_HALF_RST, dtpc_pkg::FOCAL_X_RECIP_RST,
                dtpc_pkg::FOCAL_Y_RECIP_RST, 24'd2);
    send_pixel(16'd700, 12'd4, 12'd8, 8'h10, 8'h20, 8'h30);
    send_pixel(16'd700, 12'd2, 12'd4, 8'h11, 8'h21, 8'h31);
    send_pixel(16'd700, 12'd4, 12'd6, 8'h12, 8'h22, 8'h32);
    load_config(dtpc_pkg::DEPTH_RECIP_RST, dtpc_pkg::CENTER_X_HALF_RST,
                dtpc_pkg::CENTER_Y_HALF_RST, dtpc_pkg::FOCAL_X_RECIP_RST,
                dtpc_pkg::FOCAL_Y_RECIP_RST, 24'd3);
    send_pixel(16'd900, 12'd8, 12'd16, 8'h40, 8'h50, 8'h60);
    send_pixel(16'd900, 12'd12, 12'd8, 8'h41, 8'h51, 8'h61);
  endtask

  task automatic test_depth_overflow();
    load_config(24'hFF_FFFF, dtpc_pkg::CENTER_X_HALF_RST, dtpc_pkg::CENTER_Y_HALF_RST,
                dtpc_pkg::FOCAL_X_RECIP_RST, dtpc_pkg::FOCAL_Y_RECIP_RST,
                dtpc_pkg::STRIDE_LOG2_RST);
    send_pixel(16'hFFFF, 12'd640, 12'd480, 8'h77, 8'h88, 8'h99);
    send_pixel(16'd256, 12'd0, 12'd0, 8'h66, 8'h55, 8'h44);
  endtask

  task automatic test_coord_saturation();
    load_config(24'hFF_FFFF, 24'd0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0);
    send_pixel(16'hFFFF, 12'd4095, 12'd4095, 8'hF0, 8'h0F, 8'hAA);
    load_config(24'hFF_FFFF, 24'h1FFF, 24'h1FFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0);
    send_pixel(16'hFFFF, 12'd0, 12'd0, 8'h0F, 8'hF0, 8'h55);
  endtask

  task automatic test_zero_reciprocals();
    load_config(24'd0, dtpc_pkg::CENTER_X_HALF_RST, dtpc_pkg::CENTER_Y_HALF_RST,
                dtpc_pkg::FOCAL_X_RECIP_RST, dtpc_pkg::FOCAL_Y_RECIP_RST,
                dtpc_pkg::STRIDE_LOG2_RST);
    send_pixel(16'd40000, 12'd100, 12'd100, 8'h13, 8'h57, 8'h9B);
    load_config(dtpc_pkg::DEPTH_RECIP_RST, dtpc_pkg::CENTER_X_HALF_RST,
                dtpc_pkg::CENTER_Y_HALF_RST, 24'd0, 24'd0, dtpc_pkg::STRIDE_LOG2_RST);
    send_pixel(16'd40000, 12'd100, 12'd100, 8'h24, 8'h68, 8'hAC);
  endtask

  task automatic test_unknown_index();
    load_config(dtpc_pkg::DEPTH_RECIP_RST, dtpc_pkg::CENTER_X_HALF_RST,
                dtpc_pkg::CENTER_Y_HALF_RST, dtpc_pkg::FOCAL_X_RECIP_RST,
                dtpc_pkg::FOCAL_Y_RECIP_RST, dtpc_pkg::STRIDE_LOG2_RST);
    write_register(REG_SPARE, 24'h00_0003);
    write_register(REG_TOP, 24'hFF_FFFF);
    send_pixel(16'd2000, 12'd200, 12'd300, 8'hDE, 8'hAD, 8'hBE);
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_config(dtpc_pkg::DEPTH_RECIP_RST, dtpc_pkg::CENTER_X_HALF_RST,
                       dtpc_pkg::CENTER_Y_HALF_RST, dtpc_pkg::FOCAL_X_RECIP_RST,
                       dtpc_pkg::FOCAL_Y_RECIP_RST, dtpc_pkg::STRIDE_LOG2_RST);
        1: load_config(24'hFF_FFFF, 24'h1FFF, 24'h1FFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'd3);
        2: load_config(24'd1, 24'd0, 24'd0, 24'd1, 24'd1, 24'd0);
        default: load_config(pick_recip(dtpc_pkg::DEPTH_RECIP_RST),
                             pick_centre(dtpc_pkg::CENTER_X_HALF_RST),
                             pick_centre(dtpc_pkg::CENTER_Y_HALF_RST),
                             pick_recip(dtpc_pkg::FOCAL_X_RECIP_RST),
                             pick_recip(dtpc_pkg::FOCAL_Y_RECIP_RST), pick_stride());
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // The long hold-off fills the pipeline while requests keep coming.
        if (phase % 3 == 1 && i == 20) hold_offs_asked++;
        if (phase % 4 == 2 && i == 50) wait_idle();
        send_random_pixel();
      end
    end
  endtask

  initial begin
    pix_if.valid     = 1'b0;
    pix_if.depth_raw = '0;
    pix_if.pixel_col = '0;
    pix_if.pixel_row = '0;
    pix_if.red       = '0;
    pix_if.green     = '0;
    pix_if.blue      = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_no_measurement();
    test_sampling_grid();
    test_depth_overflow();
    test_coord_saturation();
    test_zero_reciprocals();
    test_unknown_index();
    test_random_stream();

    wait_idle();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: depth_to_point_cloud.f
src/dtpc_pkg.sv
src/dtpc_in_if.sv
src/dtpc_out_if.sv
src/dtpc_cfg_if.sv
src/depth_to_point_cloud.sv
verif/depth_to_point_cloud_test.sv
